// ===== hw/rtl/kpf_pkg.sv =====
`default_nettype none
package kpf_pkg;

  localparam int WORD_BITS     = 48;
  localparam int FRAC_BITS_DEF = 32;
  localparam int CFG_BITS      = 47;
  localparam int ITER_BITS     = 4;
  localparam int RAM_DEPTH     = 64;
  localparam int ADDR_BITS     = $clog2(RAM_DEPTH);
  localparam int ROM_DEPTH     = 256;
  localparam int PC_BITS       = $clog2(ROM_DEPTH);
  localparam int PADDR_BITS    = 6;
  localparam int PDATA_BITS    = 64;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t MAXW = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t MINW = {1'b1, {(WORD_BITS-1){1'b0}}};

  // register indexes on the configuration port
  localparam logic [2:0] REG_Q_LAT = 3'd0;
  localparam logic [2:0] REG_Q_LON = 3'd1;
  localparam logic [2:0] REG_Q_ALT = 3'd2;
  localparam logic [2:0] REG_R_LAT = 3'd3;
  localparam logic [2:0] REG_R_LON = 3'd4;
  localparam logic [2:0] REG_R_ALT = 3'd5;
  localparam logic [2:0] REG_ITER  = 3'd6;

  typedef struct packed {
    word_t prior_lat;
    word_t prior_lon;
    word_t prior_alt;
    word_t meas_lat;
    word_t meas_lon;
    word_t meas_alt;
    logic  restart;
  } in_item_t;

  typedef struct packed {
    word_t est_lat;
    word_t est_lon;
    word_t est_alt;
    logic  singular;
  } out_item_t;

  typedef struct packed {
    logic [2:0][CFG_BITS-1:0] q;
    logic [2:0][CFG_BITS-1:0] r;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_END, OP_LD, OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
    OP_OUTM, OP_JNR, OP_JNZ, OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    SEL_PRIOR0, SEL_PRIOR1, SEL_PRIOR2, SEL_MEAS0, SEL_MEAS1, SEL_MEAS2,
    SEL_Q0, SEL_Q1, SEL_Q2, SEL_R0, SEL_R1, SEL_R2, SEL_ONE, SEL_ZERO
  } sel_t;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EXEC, ST_WAIT} st_t;

  typedef struct packed {
    op_t                  op;
    sel_t                 sel;
    logic [ADDR_BITS-1:0] dst;
    logic [ADDR_BITS-1:0] a;
    logic [ADDR_BITS-1:0] b;
    logic [PC_BITS-1:0]   tgt;
  } uinst_t;

  typedef uinst_t [ROM_DEPTH-1:0] rom_t;

  // scratch memory map
  localparam int A_P   = 0;
  localparam int A_Q   = 6;
  localparam int A_R   = 9;
  localparam int A_PR  = 12;
  localparam int A_MS  = 15;
  localparam int A_S   = 18;
  localparam int A_ADJ = 24;
  localparam int A_DET = 30;
  localparam int A_K   = 31;
  localparam int A_DV  = 40;
  localparam int A_T0  = 43;
  localparam int A_T1  = 44;
  localparam int A_PN  = 45;

  localparam logic [PC_BITS-1:0] PC_INIT = '0;
  localparam logic [PC_BITS-1:0] PC_ITEM = PC_BITS'(7);

  function automatic logic [WORD_BITS-1:0] mag(word_t v);
    return v[WORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic word_t sat_add(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? MINW : MAXW;
    return s[WORD_BITS-1:0];
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? MINW : MAXW;
    return s[WORD_BITS-1:0];
  endfunction

  // packed upper-triangle index of a symmetric 3x3
  function automatic int symi(int i, int j);
    int lo;
    int hi;
    lo = (i < j) ? i : j;
    hi = (i < j) ? j : i;
    if (lo == 0) return hi;
    if (lo == 1) return hi + 2;
    return 5;
  endfunction

  function automatic uinst_t mk(op_t op, sel_t sel, int dst, int a, int b, int tgt);
    uinst_t u;
    u.op  = op;
    u.sel = sel;
    u.dst = ADDR_BITS'(dst);
    u.a   = ADDR_BITS'(a);
    u.b   = ADDR_BITS'(b);
    u.tgt = PC_BITS'(tgt);
    return u;
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    int n;
    int jr;
    int jz;
    int i;
    int j;
    int k;
    int ca[6] = '{3, 2, 1, 0, 1, 0};
    int cb[6] = '{5, 4, 4, 5, 2, 3};
    int cc[6] = '{4, 1, 2, 2, 0, 1};
    int cd[6] = '{4, 5, 3, 2, 4, 1};
    rom = '0;
    n = 0;
    // power-up: identity covariance
    for (k = 0; k < 6; k++) begin
      rom[n] = mk(OP_LD, (k == 0 || k == 3 || k == 5) ? SEL_ONE : SEL_ZERO,
                  A_P + k, 0, 0, 0);
      n++;
    end
    rom[n] = mk(OP_END, SEL_ZERO, 0, 0, 0, 0); n++;
    // item entry
    for (i = 0; i < 3; i++) begin
      rom[n] = mk(OP_LD, sel_t'(i), A_PR + i, 0, 0, 0); n++;
      rom[n] = mk(OP_LD, sel_t'(3 + i), A_MS + i, 0, 0, 0); n++;
      rom[n] = mk(OP_LD, sel_t'(6 + i), A_Q + i, 0, 0, 0); n++;
      rom[n] = mk(OP_LD, sel_t'(9 + i), A_R + i, 0, 0, 0); n++;
    end
    jr = n; n++;
    for (k = 0; k < 6; k++) begin
      rom[n] = mk(OP_LD, (k == 0) ? SEL_Q0 : (k == 3) ? SEL_Q1 : (k == 5) ? SEL_Q2 : SEL_ZERO,
                  A_P + k, 0, 0, 0);
      n++;
    end
    rom[jr] = mk(OP_JNR, SEL_ZERO, 0, 0, 0, n);
    for (i = 0; i < 3; i++) begin
      rom[n] = mk(OP_ADD, SEL_ZERO, A_P + symi(i, i), A_P + symi(i, i), A_Q + i, 0); n++;
    end
    for (k = 0; k < 6; k++) begin
      rom[n] = mk(OP_MOV, SEL_ZERO, A_S + k, A_P + k, 0, 0); n++;
    end
    for (i = 0; i < 3; i++) begin
      rom[n] = mk(OP_ADD, SEL_ZERO, A_S + symi(i, i), A_S + symi(i, i), A_R + i, 0); n++;
    end
    for (k = 0; k < 6; k++) begin
      rom[n] = mk(OP_MUL, SEL_ZERO, A_T0, A_S + ca[k], A_S + cb[k], 0); n++;
      rom[n] = mk(OP_MUL, SEL_ZERO, A_T1, A_S + cc[k], A_S + cd[k], 0); n++;
      rom[n] = mk(OP_SUB, SEL_ZERO, A_ADJ + k, A_T0, A_T1, 0); n++;
    end
    rom[n] = mk(OP_MUL, SEL_ZERO, A_T0, A_S + 0, A_ADJ + 0, 0); n++;
    rom[n] = mk(OP_MUL, SEL_ZERO, A_T1, A_S + 1, A_ADJ + 1, 0); n++;
    rom[n] = mk(OP_ADD, SEL_ZERO, A_T0, A_T0, A_T1, 0); n++;
    rom[n] = mk(OP_MUL, SEL_ZERO, A_T1, A_S + 2, A_ADJ + 2, 0); n++;
    rom[n] = mk(OP_ADD, SEL_ZERO, A_DET, A_T0, A_T1, 0); n++;
    jz = n; n++;
    // singular: pass the prior through
    for (i = 0; i < 3; i++) begin
      rom[n] = mk(OP_OUTM, SEL_ZERO, i, A_PR + i, 0, 0); n++;
    end
    rom[n] = mk(OP_EMIT, SEL_ZERO, 1, 0, 0, 0); n++;
    rom[n] = mk(OP_END, SEL_ZERO, 0, 0, 0, 0); n++;
    rom[jz] = mk(OP_JNZ, SEL_ZERO, 0, A_DET, 0, n);
    // gain
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        rom[n] = mk(OP_MUL, SEL_ZERO, A_T0, A_P + symi(i, 0), A_ADJ + symi(0, j), 0); n++;
        rom[n] = mk(OP_MUL, SEL_ZERO, A_T1, A_P + symi(i, 1), A_ADJ + symi(1, j), 0); n++;
        rom[n] = mk(OP_ADD, SEL_ZERO, A_T0, A_T0, A_T1, 0); n++;
        rom[n] = mk(OP_MUL, SEL_ZERO, A_T1, A_P + symi(i, 2), A_ADJ + symi(2, j), 0); n++;
        rom[n] = mk(OP_ADD, SEL_ZERO, A_T0, A_T0, A_T1, 0); n++;
        rom[n] = mk(OP_DIV, SEL_ZERO, A_K + 3 * i + j, A_T0, A_DET, 0); n++;
      end
    end
    for (i = 0; i < 3; i++) begin
      rom[n] = mk(OP_SUB, SEL_ZERO, A_DV + i, A_MS + i, A_PR + i, 0); n++;
    end
    // estimate
    for (i = 0; i < 3; i++) begin
      rom[n] = mk(OP_MUL, SEL_ZERO, A_T0, A_K + 3 * i, A_DV + 0, 0); n++;
      rom[n] = mk(OP_MUL, SEL_ZERO, A_T1, A_K + 3 * i + 1, A_DV + 1, 0); n++;
      rom[n] = mk(OP_ADD, SEL_ZERO, A_T0, A_T0, A_T1, 0); n++;
      rom[n] = mk(OP_MUL, SEL_ZERO, A_T1, A_K + 3 * i + 2, A_DV + 2, 0); n++;
      rom[n] = mk(OP_ADD, SEL_ZERO, A_T0, A_T0, A_T1, 0); n++;
      rom[n] = mk(OP_ADD, SEL_ZERO, A_T0, A_PR + i, A_T0, 0); n++;
      rom[n] = mk(OP_OUTM, SEL_ZERO, i, A_T0, 0, 0); n++;
    end
    rom[n] = mk(OP_EMIT, SEL_ZERO, 0, 0, 0, 0); n++;
    // covariance update
    for (i = 0; i < 3; i++) begin
      for (j = i; j < 3; j++) begin
        rom[n] = mk(OP_MUL, SEL_ZERO, A_T0, A_K + 3 * i, A_P + symi(0, j), 0); n++;
        rom[n] = mk(OP_MUL, SEL_ZERO, A_T1, A_K + 3 * i + 1, A_P + symi(1, j), 0); n++;
        rom[n] = mk(OP_ADD, SEL_ZERO, A_T0, A_T0, A_T1, 0); n++;
        rom[n] = mk(OP_MUL, SEL_ZERO, A_T1, A_K + 3 * i + 2, A_P + symi(2, j), 0); n++;
        rom[n] = mk(OP_ADD, SEL_ZERO, A_T0, A_T0, A_T1, 0); n++;
        rom[n] = mk(OP_SUB, SEL_ZERO, A_PN + symi(i, j), A_P + symi(i, j), A_T0, 0); n++;
      end
    end
    for (k = 0; k < 6; k++) begin
      rom[n] = mk(OP_MOV, SEL_ZERO, A_P + k, A_PN + k, 0, 0); n++;
    end
    rom[n] = mk(OP_END, SEL_ZERO, 0, 0, 0, 0);
    return rom;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/kpf_ram.sv =====
`default_nettype none
module kpf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/kpf_mul.sv =====
`default_nettype none
module kpf_mul #(
  parameter int FRAC_BITS = kpf_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire kpf_pkg::word_t a,
  input  wire kpf_pkg::word_t b,
  output logic               done,
  output kpf_pkg::word_t     y
);
  import kpf_pkg::*;

  localparam int H = WORD_BITS / 2;
  localparam int PW = 2 * WORD_BITS;
  localparam logic [PW-1:0] LIM_NEG = PW'(1) << (WORD_BITS - 1);
  localparam logic [PW-1:0] LIM_POS = PW'(unsigned'(MAXW));

  logic [WORD_BITS-1:0] ma, mb;
  logic                 neg, busy;
  logic [2:0]           step;
  logic [H-1:0]         pa, pb;
  logic [2*H-1:0]       prod;
  logic [PW-1:0]        acc, term, shifted;

  // four half-width partial products, one per cycle
  always_comb begin
    case (step)
      3'd0:    begin pa = ma[H-1:0];         pb = mb[H-1:0];         end
      3'd1:    begin pa = ma[H-1:0];         pb = mb[WORD_BITS-1:H]; end
      3'd2:    begin pa = ma[WORD_BITS-1:H]; pb = mb[H-1:0];         end
      default: begin pa = ma[WORD_BITS-1:H]; pb = mb[WORD_BITS-1:H]; end
    endcase
    case (step)
      3'd1:    term = PW'(prod);
      3'd2:    term = PW'(prod) << H;
      3'd3:    term = PW'(prod) << H;
      default: term = PW'(prod) << (2 * H);
    endcase
    shifted = acc >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ma   <= mag(a);
        mb   <= mag(b);
        neg  <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
        acc  <= '0;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (step < 3'd4) prod <= pa * pb;
        if (step >= 3'd1 && step <= 3'd4) acc <= acc + term;
        if (step == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (neg) y <= (shifted > LIM_NEG) ? MINW : word_t'(~shifted[WORD_BITS-1:0] + 1'b1);
          else     y <= (shifted > LIM_POS) ? MAXW : word_t'(shifted[WORD_BITS-1:0]);
        end
        step <= step + 3'd1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/kpf_div.sv =====
`default_nettype none
module kpf_div #(
  parameter int FRAC_BITS = kpf_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire kpf_pkg::word_t num,
  input  wire kpf_pkg::word_t den,
  output logic               done,
  output kpf_pkg::word_t     y
);
  import kpf_pkg::*;

  localparam int NB = WORD_BITS + FRAC_BITS;
  localparam int CB = $clog2(NB + 1);
  localparam logic [NB-1:0] LIM_NEG = NB'(1) << (WORD_BITS - 1);
  localparam logic [NB-1:0] LIM_POS = NB'(unsigned'(MAXW));

  logic [NB-1:0]        x, q;
  logic [WORD_BITS-1:0] d, r;
  logic [WORD_BITS:0]   r2, rsub;
  logic                 neg, busy, ge;
  logic [CB-1:0]        cnt;

  always_comb begin
    r2   = {r, x[NB-1]};
    ge   = r2 >= {1'b0, d};
    rsub = r2 - {1'b0, d};
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= NB'(mag(num)) << FRAC_BITS;
        d    <= mag(den);
        neg  <= num[WORD_BITS-1] ^ den[WORD_BITS-1];
        r    <= '0;
        q    <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt != CB'(NB)) begin
          r   <= ge ? rsub[WORD_BITS-1:0] : r2[WORD_BITS-1:0];
          q   <= {q[NB-2:0], ge};
          x   <= x << 1;
          cnt <= cnt + 1'b1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          if (neg) y <= (q > LIM_NEG) ? MINW : word_t'(~q[WORD_BITS-1:0] + 1'b1);
          else     y <= (q > LIM_POS) ? MAXW : word_t'(q[WORD_BITS-1:0]);
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/kpf_core.sv =====
`default_nettype none
module kpf_core #(
  parameter int FRAC_BITS = kpf_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire kpf_pkg::cfg_t cfg,
  input  wire logic          start,
  input  wire kpf_pkg::in_item_t in_item,
  output logic               idle,
  output logic               out_valid,
  input  wire logic          out_stall,
  output kpf_pkg::out_item_t out_data
);
  import kpf_pkg::*;

  localparam word_t ONE = word_t'(1) << FRAC_BITS;
  localparam rom_t  ROM = build_rom();

  st_t                  state, state_next;
  logic [PC_BITS-1:0]   pc, pc_next;
  uinst_t               ir, cur;
  in_item_t             hold;
  word_t                stage [3];
  word_t                ra, rb, wdata, sel_val, unit_y;
  logic                 we, mul_start, div_start, mul_done, div_done, unit_done;
  logic                 emit, outm;
  word_t                mul_y, div_y;

  assign cur  = ROM[pc];
  assign idle = (state == ST_IDLE);

  kpf_ram #(.WIDTH(WORD_BITS), .DEPTH(RAM_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(ir.dst), .wdata(wdata),
    .raddr_a(cur.a), .raddr_b(cur.b), .rdata_a(ra), .rdata_b(rb)
  );

  kpf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(ra), .b(rb), .done(mul_done), .y(mul_y)
  );

  kpf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(ra), .den(rb), .done(div_done), .y(div_y)
  );

  always_comb begin
    unique case (ir.sel)
      SEL_PRIOR0: sel_val = hold.prior_lat;
      SEL_PRIOR1: sel_val = hold.prior_lon;
      SEL_PRIOR2: sel_val = hold.prior_alt;
      SEL_MEAS0:  sel_val = hold.meas_lat;
      SEL_MEAS1:  sel_val = hold.meas_lon;
      SEL_MEAS2:  sel_val = hold.meas_alt;
      SEL_Q0:     sel_val = word_t'({1'b0, cfg.q[0]});
      SEL_Q1:     sel_val = word_t'({1'b0, cfg.q[1]});
      SEL_Q2:     sel_val = word_t'({1'b0, cfg.q[2]});
      SEL_R0:     sel_val = word_t'({1'b0, cfg.r[0]});
      SEL_R1:     sel_val = word_t'({1'b0, cfg.r[1]});
      SEL_R2:     sel_val = word_t'({1'b0, cfg.r[2]});
      SEL_ONE:    sel_val = ONE;
      default:    sel_val = '0;
    endcase
    unit_done = (ir.op == OP_DIV) ? div_done : mul_done;
    unit_y    = (ir.op == OP_DIV) ? div_y : mul_y;
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    we         = 1'b0;
    wdata      = ra;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    emit       = 1'b0;
    outm       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          pc_next    = PC_ITEM;
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: begin
        pc_next    = pc + 1'b1;
        state_next = ST_READ;
        case (ir.op)
          OP_LD:   begin we = 1'b1; wdata = sel_val; end
          OP_MOV:  we = 1'b1;
          OP_ADD:  begin we = 1'b1; wdata = sat_add(ra, rb); end
          OP_SUB:  begin we = 1'b1; wdata = sat_sub(ra, rb); end
          OP_MUL:  begin mul_start = 1'b1; pc_next = pc; state_next = ST_WAIT; end
          OP_DIV:  begin div_start = 1'b1; pc_next = pc; state_next = ST_WAIT; end
          OP_OUTM: outm = 1'b1;
          OP_JNR:  if (!hold.restart) pc_next = ir.tgt;
          OP_JNZ:  if (ra != '0) pc_next = ir.tgt;
          OP_EMIT: begin
            // hold until the output register is free
            if (out_valid && out_stall) begin
              pc_next    = pc;
              state_next = ST_EXEC;
            end else begin
              emit = 1'b1;
            end
          end
          default: begin pc_next = pc; state_next = ST_IDLE; end
        endcase
      end
      ST_WAIT: begin
        if (unit_done) begin
          we         = 1'b1;
          wdata      = unit_y;
          pc_next    = pc + 1'b1;
          state_next = ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_READ;
      pc        <= PC_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      out_valid <= emit || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) ir <= cur;
    if (start && idle) hold <= in_item;
    if (outm) begin
      case (ir.dst[1:0])
        2'd0:    stage[0] <= ra;
        2'd1:    stage[1] <= ra;
        default: stage[2] <= ra;
      endcase
    end
    if (emit) begin
      out_data.est_lat  <= stage[0];
      out_data.est_lon  <= stage[1];
      out_data.est_alt  <= stage[2];
      out_data.singular <= ir.dst[0];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/kalman_position_fuser_3axis.sv =====
`default_nettype none
// Three-axis Kalman position fuser with identity process and measurement
// models, signed Q16.32 arithmetic that saturates at every operation. A
// microcoded sequencer walks a fixed program over a 64-word scratch RAM, one
// shared multi-cycle multiplier (four 24x24 partial products) and one shared
// restoring divider (one quotient bit per cycle, 80 bits). A full item runs
// nine gain divides and 69 multiplies besides moves, adds and jumps before
// the input opens again, and a restart adds a reload of the covariance. A
// singular innovation covariance ends the program early. in_stall stays high
// while an item is in work; the result is registered and may wait on
// out_stall while the next item is taken, and a stalled result holds the
// next one at its output step. After reset a routine loads the identity
// covariance before the first item is taken. The iterations register is
// stored and read back only.
module kalman_position_fuser_3axis #(
  parameter int FRAC_BITS = kpf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire kpf_pkg::in_item_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output kpf_pkg::out_item_t                    out_data,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [kpf_pkg::PADDR_BITS-1:0]   paddr,
  input  wire logic [kpf_pkg::PDATA_BITS-1:0]   pwdata,
  output logic      [kpf_pkg::PDATA_BITS-1:0]   prdata,
  output logic                                  pready
);
  import kpf_pkg::*;

  cfg_t                 cfg;
  logic [ITER_BITS-1:0] iterations;
  logic [2:0]           ridx;
  logic                 wr, idle, in_accept;

  assign pready    = 1'b1;
  assign ridx      = paddr[5:3];
  assign wr        = psel && penable && pwrite && pready;
  assign in_stall  = !idle;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.q      <= {3{CFG_BITS'(64'h1_0000_0000)}};
      cfg.r      <= {3{CFG_BITS'(64'h5_0000_0000)}};
      iterations <= ITER_BITS'(5);
    end else if (wr) begin
      unique case (ridx)
        REG_Q_LAT: cfg.q[0]   <= pwdata[CFG_BITS-1:0];
        REG_Q_LON: cfg.q[1]   <= pwdata[CFG_BITS-1:0];
        REG_Q_ALT: cfg.q[2]   <= pwdata[CFG_BITS-1:0];
        REG_R_LAT: cfg.r[0]   <= pwdata[CFG_BITS-1:0];
        REG_R_LON: cfg.r[1]   <= pwdata[CFG_BITS-1:0];
        REG_R_ALT: cfg.r[2]   <= pwdata[CFG_BITS-1:0];
        REG_ITER:  iterations <= pwdata[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_Q_LAT: prdata = PDATA_BITS'(cfg.q[0]);
      REG_Q_LON: prdata = PDATA_BITS'(cfg.q[1]);
      REG_Q_ALT: prdata = PDATA_BITS'(cfg.q[2]);
      REG_R_LAT: prdata = PDATA_BITS'(cfg.r[0]);
      REG_R_LON: prdata = PDATA_BITS'(cfg.r[1]);
      REG_R_ALT: prdata = PDATA_BITS'(cfg.r[2]);
      REG_ITER:  prdata = PDATA_BITS'(iterations);
      default:   prdata = '0;
    endcase
  end

  kpf_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk(clk), .rst(rst), .cfg(cfg), .start(in_accept), .in_item(in_data),
    .idle(idle), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // an accepted item keeps the input side closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall) else $error("input open right after accept");

  // a result appears only while an item is in work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall)) else $error("result without work");

  // a waiting result is not dropped
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("stalled result lost");
endmodule
`default_nettype wire
